// ===== sv/dqs_pkg.sv =====
// ---------------------------------------------------------------------------
// dqs_pkg: shared types and codes for the deque with value search
// Request and response item layouts, request and status codes, cell
// operations and controller states.
// ---------------------------------------------------------------------------
`default_nettype none

package dqs_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;

  // request codes
  localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [2:0] REQ_POP_BACK   = 3'd3;
  localparam logic [2:0] REQ_SEARCH     = 3'd4;

  // status codes
  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic [2:0]               req_type;
    logic signed [DATA_W-1:0] value;
  } req_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       found;
    logic [3:0] position;
    logic [4:0] occupancy;
  } rsp_item_t;

  // what every cell does this cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT_UP,    // take the lower neighbor (push at front)
    CELL_SHIFT_DOWN,  // take the upper neighbor, last cell wraps (pop front, search)
    CELL_WRITE        // the selected cell loads the write data (push at back)
  } cell_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_REPLY
  } ctl_state_t;

endpackage

`default_nettype wire

// ===== sv/dqs_cell.sv =====
// ---------------------------------------------------------------------------
// dqs_cell: one slot of the deque chain
// Holds one entry and moves it to or from its neighbors on command.
// ---------------------------------------------------------------------------
`default_nettype none

module dqs_cell
  import dqs_pkg::*;
(
  input  wire logic              clk,
  input  wire cell_op_t          op,
  input  wire logic              wr_en,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [DATA_W-1:0] lower,
  input  wire logic [DATA_W-1:0] upper,
  output logic      [DATA_W-1:0] q
);

  // entry register, payload only
  always_ff @(posedge clk) begin
    case (op)
      CELL_SHIFT_UP:   q <= lower;
      CELL_SHIFT_DOWN: q <= upper;
      CELL_WRITE: begin
        if (wr_en) q <= wdata;
      end
      default: q <= q;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/deque_with_value_search_top.sv =====
// ---------------------------------------------------------------------------
// deque_with_value_search_top: bounded deque of 32-bit values with search
// Entries sit in a chain of cells in logical order, front in cell 0.
// A search rotates the chain once around and compares at cell 0.
// ---------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | req_type, value
//  rsp     | out       | rsp_valid/rsp_stall  | status, found, position, occupancy
//
//  Push and pop: result registered at the accepting edge.
//  Search: the chain rotates once around in S_SEARCH, S_REPLY registers the result
//  once the result register is free; no new item is taken before S_IDLE.
//  Reset clears the entry count and the controller; cell contents stay.
//  A stalled result holds; a new item is taken only when the result
//  register is empty or drains in the same cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module deque_with_value_search_top
  import dqs_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  output logic           req_stall,
  input  wire req_item_t req,
  output logic           rsp_valid,
  input  wire logic      rsp_stall,
  output rsp_item_t      rsp
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = IW + 1;

  ctl_state_t          state, state_next;
  logic [CW-1:0]       count, count_next;
  logic [IW-1:0]       k;
  logic                found;
  logic [IW-1:0]       match_pos;
  logic [DATA_W-1:0]   sval;
  cell_op_t            op;
  logic [DATA_W-1:0]   cq [DEPTH];
  logic                req_acc, slot_free, is_full, is_empty;
  logic                load_rsp;
  rsp_item_t           rsp_new;
  logic [CW+4:0]       occ_ext;
  logic [IW+3:0]       pos_ext;
  logic [1:0]          stat_now;

  assign slot_free = !rsp_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE) || !slot_free;
  assign req_acc   = req_valid && !req_stall;
  assign is_full   = (count == CW'(DEPTH));
  assign is_empty  = (count == '0);

  // cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] lo, hi;
    assign lo = (i == 0) ? req.value : cq[(i == 0) ? 0 : i - 1];
    assign hi = cq[(i + 1) % DEPTH];
    dqs_cell u_cell (
      .clk   (clk),
      .op    (op),
      .wr_en (count == CW'(i)),
      .wdata (req.value),
      .lower (lo),
      .upper (hi),
      .q     (cq[i])
    );
  end

  // cell command, count update and immediate status
  always_comb begin
    op         = CELL_HOLD;
    count_next = count;
    stat_now   = STAT_DONE;
    if (state == S_SEARCH) begin
      op = CELL_SHIFT_DOWN;
    end else if (state == S_IDLE && req_acc) begin
      case (req.req_type)
        REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
          if (is_full) begin
            stat_now = STAT_FULL;
          end else begin
            op         = (req.req_type == REQ_PUSH_FRONT) ? CELL_SHIFT_UP : CELL_WRITE;
            count_next = count + 1'b1;
          end
        end
        REQ_POP_FRONT, REQ_POP_BACK: begin
          if (is_empty) begin
            stat_now = STAT_EMPTY;
          end else begin
            op         = (req.req_type == REQ_POP_FRONT) ? CELL_SHIFT_DOWN : CELL_HOLD;
            count_next = count - 1'b1;
          end
        end
        default: op = CELL_HOLD;
      endcase
    end
  end

  // next state and result assembly
  always_comb begin
    state_next = state;
    load_rsp   = 1'b0;
    occ_ext    = {5'b0, count_next};
    pos_ext    = {4'b0, match_pos};
    rsp_new    = '{status: stat_now, found: 1'b0, position: 4'd0,
                   occupancy: occ_ext[4:0]};
    case (state)
      S_IDLE: begin
        if (req_acc) begin
          if (req.req_type == REQ_SEARCH) state_next = S_SEARCH;
          else load_rsp = 1'b1;
        end
      end
      S_SEARCH: begin
        if (k == IW'(DEPTH - 1)) state_next = S_REPLY;
      end
      S_REPLY: begin
        rsp_new = '{status: STAT_DONE, found: found, position: pos_ext[3:0],
                    occupancy: occ_ext[4:0]};
        if (slot_free) begin
          load_rsp   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // search walk: cell 0 shows the entry at position k
  always_ff @(posedge clk) begin
    if (rst) begin
      k     <= '0;
      found <= 1'b0;
    end else if (state == S_IDLE && req_acc) begin
      k     <= '0;
      found <= 1'b0;
    end else if (state == S_SEARCH) begin
      k <= k + 1'b1;
      if (!found && ({1'b0, k} < count) && (cq[0] == sval)) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_acc) begin
      sval      <= req.value;
      match_pos <= '0;
    end else if (state == S_SEARCH && !found && ({1'b0, k} < count) && (cq[0] == sval)) begin
      match_pos <= k;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_rsp) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) rsp <= rsp_new;
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH)) else $error("entry count above depth");

  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> req_stall) else $error("item taken during search");

  a_quick_result: assert property (@(posedge clk) disable iff (rst)
    req_acc && req.req_type != REQ_SEARCH |=> rsp_valid)
    else $error("push or pop gave no result");

  a_walk_ends: assert property (@(posedge clk) disable iff (rst)
    state == S_SEARCH && k == IW'(DEPTH - 1) |=> state == S_REPLY)
    else $error("search walk did not end");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |=> $stable(count)) else $error("count moved during search");

endmodule

`default_nettype wire
